// ===== design/pals_pkg.sv =====
// shared types and constants for the polyline arc-length sampler
package pals_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int LEN_BITS = 24;
   localparam int FRAC_BITS = 17;
   localparam int T_BITS = 17;
   localparam int SEG_BITS = 6;
   localparam int SQ_BITS = 2 * DIFF_BITS;
   localparam int TGT_BITS = FRAC_BITS + LEN_BITS;
   localparam int ITER_BITS = 5;
   localparam int ROOT_STEPS = SQ_BITS / 2;
   localparam logic [FRAC_BITS-1:0] FRAC_ONE = FRAC_BITS'(65536);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DROPPED   = 2'd2,
      ST_NO_PATH   = 2'd3
   } status_type;

   typedef struct packed {
      op_type                        op;
      logic signed [COORD_BITS-1:0]  x;
      logic signed [COORD_BITS-1:0]  y;
      logic                          last;
      logic [FRAC_BITS-1:0]          frac;
   } cmd_type;

endpackage

// ===== design/pals_req_if.sv =====
// request channel: vertex loads and point queries
interface pals_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   req_type;
   logic signed [pals_pkg::COORD_BITS-1:0] vertex_x;
   logic signed [pals_pkg::COORD_BITS-1:0] vertex_y;
   logic                                   last_vertex;
   logic [pals_pkg::FRAC_BITS-1:0]         fraction;

   modport source (output valid, req_type, vertex_x, vertex_y, last_vertex, fraction,
                   input ready);
   modport sink (input valid, req_type, vertex_x, vertex_y, last_vertex, fraction,
                 output ready);
endinterface

// ===== design/pals_rsp_if.sv =====
// response channel: sampled position and status
interface pals_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pals_pkg::COORD_BITS-1:0] pos_x;
   logic signed [pals_pkg::COORD_BITS-1:0] pos_y;
   logic [pals_pkg::SEG_BITS-1:0]          segment_index;
   logic [1:0]                             status;

   modport source (output valid, pos_x, pos_y, segment_index, status, input ready);
   modport sink (input valid, pos_x, pos_y, segment_index, status, output ready);
endinterface

// ===== design/pals_front.sv =====
// front end: classifies request beats and queues them for the back end
module pals_front (
   input  logic                 clock,
   input  logic                 reset,
   pals_req_if.sink             req,
   output logic                 cmd_valid,
   output pals_pkg::cmd_type    cmd,
   input  logic                 cmd_pop
);

   pals_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   pals_pkg::cmd_type cls;
   logic       push;

   // classify: decode op and clamp the fraction to one
   always_comb begin
      cls.op   = req.req_type ? pals_pkg::OP_QUERY : pals_pkg::OP_LOAD;
      cls.x    = req.vertex_x;
      cls.y    = req.vertex_y;
      cls.last = req.last_vertex;
      cls.frac = (req.fraction > pals_pkg::FRAC_ONE) ? pals_pkg::FRAC_ONE : req.fraction;
   end

   assign req.ready = (fill_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   // two-entry queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

   // queue pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, cmd_pop})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

// ===== design/pals_back.sv =====
// back end: vertex store, segment length by square root, arc-length search and lerp
module pals_back #(
   parameter int MAX_VERTICES = pals_pkg::MAX_VERTICES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  pals_pkg::cmd_type    cmd,
   output logic                 cmd_pop,
   pals_rsp_if.source           rsp
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int CB = pals_pkg::COORD_BITS;
   localparam int DB = pals_pkg::DIFF_BITS;
   localparam int LB = pals_pkg::LEN_BITS;
   localparam int SB = pals_pkg::SQ_BITS;
   localparam int TB = pals_pkg::TGT_BITS;
   localparam int NB = pals_pkg::T_BITS;
   localparam int PB = DB + NB + 1;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_LOAD  = 13'b0000000000010,
      S_SQ    = 13'b0000000000100,
      S_SUM   = 13'b0000000001000,
      S_ROOT  = 13'b0000000010000,
      S_ACC   = 13'b0000000100000,
      S_QMUL  = 13'b0000001000000,
      S_QSC0  = 13'b0000010000000,
      S_QSCAN = 13'b0000100000000,
      S_DIV   = 13'b0001000000000,
      S_RDA   = 13'b0010000000000,
      S_RDB   = 13'b0100000000000,
      S_LERP  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      done_ff;
   logic      lerp_mul_ff;

   // vertex and length memories
   logic [CB-1:0] x_mem   [MAX_VERTICES];
   logic [CB-1:0] y_mem   [MAX_VERTICES];
   logic [LB-1:0] cum_mem [MAX_VERTICES];
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [CB-1:0] rd_x_ff, rd_y_ff;
   logic [LB-1:0] rd_cum_ff;

   // path state
   logic [CW-1:0]        count_ff;
   logic [LB-1:0]        perim_ff;
   logic                 closed_ff;
   logic [LB-1:0]        cum_last_ff;
   logic signed [CB-1:0] prev_x_ff, prev_y_ff, first_x_ff, first_y_ff;
   logic                 close_ff;
   pals_pkg::cmd_type    cmd_ff;

   // length datapath
   logic signed [DB-1:0] dx_ff, dy_ff;
   logic [DB-1:0]        ax_abs, ay_abs;
   logic [SB-1:0]        sqx_ff, sqy_ff, rad_ff, res_ff, bit_ff;
   logic [SB:0]          trial;
   logic [pals_pkg::ITER_BITS-1:0] iter_ff;
   logic [LB:0]          acc_sum, close_sum;
   logic [LB-1:0]        new_cum, new_perim;

   // query datapath
   logic [TB-1:0]        target_ff, num_ff, dvs_ff;
   logic [LB-1:0]        lo_ff;
   logic [NB-1:0]        t_ff;
   logic [AW-1:0]        seg_ff;
   logic signed [CB-1:0] ax_ff, ay_ff;
   logic signed [PB-1:0] prodx_ff, prody_ff;
   logic signed [DB-1:0] difx, dify;
   logic signed [PB:0]   rndx, rndy;
   logic [AW+pals_pkg::SEG_BITS-1:0] seg_wide;

   // response register
   logic signed [CB-1:0]          pos_x_ff, pos_y_ff;
   logic [pals_pkg::SEG_BITS-1:0] seg_out_ff;
   pals_pkg::status_type          status_ff;

   assign cmd_pop = (state_ff == S_IDLE) && !done_ff && cmd_valid;

   assign rsp.valid         = done_ff;
   assign rsp.pos_x         = pos_x_ff;
   assign rsp.pos_y         = pos_y_ff;
   assign rsp.segment_index = seg_out_ff;
   assign rsp.status        = status_ff;

   // arithmetic helpers
   assign ax_abs    = dx_ff[DB-1] ? DB'(-dx_ff) : DB'(dx_ff);
   assign ay_abs    = dy_ff[DB-1] ? DB'(-dy_ff) : DB'(dy_ff);
   assign trial     = {1'b0, res_ff} + {1'b0, bit_ff};
   assign acc_sum   = {1'b0, cum_last_ff} + (LB+1)'(res_ff);
   assign close_sum = {1'b0, perim_ff} + (LB+1)'(res_ff);
   assign new_cum   = acc_sum[LB] ? {LB{1'b1}} : acc_sum[LB-1:0];
   assign new_perim = close_sum[LB] ? {LB{1'b1}} : close_sum[LB-1:0];
   assign difx      = DB'($signed(rd_x_ff)) - DB'(ax_ff);
   assign dify      = DB'($signed(rd_y_ff)) - DB'(ay_ff);
   assign rndx      = (PB+1)'(prodx_ff) + (PB+1)'(32768);
   assign rndy      = (PB+1)'(prody_ff) + (PB+1)'(32768);
   assign seg_wide  = {{pals_pkg::SEG_BITS{1'b0}}, seg_ff};

   // memory read address by state
   always_comb begin
      case (state_ff)
         S_QSC0:  rd_addr = AW'(1);
         S_QSCAN: rd_addr = seg_ff + AW'(2);
         S_RDA:   rd_addr = seg_ff;
         S_RDB:   rd_addr = seg_ff + AW'(1);
         default: rd_addr = seg_ff;
      endcase
   end

   assign wr_en = (state_ff == S_ACC) && !close_ff;

   // memories: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[count_ff[AW-1:0]]   <= cmd_ff.x;
         y_mem[count_ff[AW-1:0]]   <= cmd_ff.y;
         cum_mem[count_ff[AW-1:0]] <= new_cum;
      end
      rd_x_ff   <= x_mem[rd_addr];
      rd_y_ff   <= y_mem[rd_addr];
      rd_cum_ff <= cum_mem[rd_addr];
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_pop) begin
               if (cmd.op == pals_pkg::OP_LOAD) begin
                  state_in = S_LOAD;
               end else if (closed_ff && count_ff >= CW'(2)) begin
                  state_in = S_QMUL;
               end
            end
         end
         S_LOAD: begin
            if (count_ff == CW'(MAX_VERTICES)) begin
               state_in = cmd_ff.last ? S_SQ : S_IDLE;
            end else if (count_ff == CW'(0)) begin
               state_in = S_ACC;
            end else begin
               state_in = S_SQ;
            end
         end
         S_SQ:   state_in = S_SUM;
         S_SUM:  state_in = S_ROOT;
         S_ROOT: state_in = (iter_ff == '0) ? S_ACC : S_ROOT;
         S_ACC: begin
            state_in = (!close_ff && cmd_ff.last) ? S_SQ : S_IDLE;
         end
         S_QMUL: state_in = S_QSC0;
         S_QSC0: state_in = S_QSCAN;
         S_QSCAN: begin
            if (target_ff <= TB'({rd_cum_ff, 16'd0})) begin
               state_in = (rd_cum_ff == lo_ff) ? S_RDA : S_DIV;
            end else if (CW'(seg_ff) + CW'(2) == count_ff) begin
               state_in = S_IDLE;
            end
         end
         S_DIV:  state_in = (iter_ff == '0) ? S_RDA : S_DIV;
         S_RDA:  state_in = S_RDB;
         S_RDB:  state_in = S_LERP;
         S_LERP: state_in = lerp_mul_ff ? S_IDLE : S_LERP;
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         done_ff   <= 1'b0;
         count_ff  <= '0;
         perim_ff  <= '0;
         closed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (done_ff && rsp.ready) begin
            done_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_pop) begin
                  if (cmd.op == pals_pkg::OP_LOAD) begin
                     // a load after close starts a fresh path
                     if (closed_ff) begin
                        count_ff  <= '0;
                        perim_ff  <= '0;
                        closed_ff <= 1'b0;
                     end
                  end else if (!(closed_ff && count_ff >= CW'(2))) begin
                     done_ff <= 1'b1;
                  end
               end
            end
            S_LOAD: begin
               if (count_ff == CW'(MAX_VERTICES) && !cmd_ff.last) begin
                  done_ff <= 1'b1;
               end
            end
            S_ACC: begin
               if (close_ff) begin
                  perim_ff  <= new_perim;
                  closed_ff <= 1'b1;
                  done_ff   <= 1'b1;
               end else begin
                  perim_ff <= new_cum;
                  count_ff <= count_ff + CW'(1);
                  if (!cmd_ff.last) begin
                     done_ff <= 1'b1;
                  end
               end
            end
            S_QSCAN: begin
               if (!(target_ff <= TB'({rd_cum_ff, 16'd0})) &&
                   CW'(seg_ff) + CW'(2) == count_ff) begin
                  done_ff <= 1'b1;
               end
            end
            S_LERP: begin
               if (lerp_mul_ff) begin
                  done_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (cmd_pop) begin
               cmd_ff     <= cmd;
               close_ff   <= 1'b0;
               pos_x_ff   <= '0;
               pos_y_ff   <= '0;
               seg_out_ff <= '0;
               status_ff  <= pals_pkg::ST_NO_PATH;
            end
         end
         S_LOAD: begin
            status_ff <= pals_pkg::ST_OK;
            if (count_ff == CW'(MAX_VERTICES)) begin
               // store full: drop, then maybe close over stored vertices
               status_ff  <= pals_pkg::ST_DROPPED;
               close_ff   <= 1'b1;
               dx_ff      <= DB'(first_x_ff) - DB'(prev_x_ff);
               dy_ff      <= DB'(first_y_ff) - DB'(prev_y_ff);
            end else if (count_ff == CW'(0)) begin
               res_ff      <= '0;
               cum_last_ff <= '0;
               first_x_ff  <= cmd_ff.x;
               first_y_ff  <= cmd_ff.y;
            end else begin
               dx_ff <= DB'(cmd_ff.x) - DB'(prev_x_ff);
               dy_ff <= DB'(cmd_ff.y) - DB'(prev_y_ff);
            end
         end
         S_SQ: begin
            sqx_ff <= SB'(ax_abs * ax_abs);
            sqy_ff <= SB'(ay_abs * ay_abs);
         end
         S_SUM: begin
            rad_ff  <= sqx_ff + sqy_ff;
            res_ff  <= '0;
            bit_ff  <= SB'(1) << (SB - 2);
            iter_ff <= pals_pkg::ITER_BITS'(pals_pkg::ROOT_STEPS - 1);
         end
         S_ROOT: begin
            // one result bit per cycle
            if ({1'b0, rad_ff} >= trial) begin
               rad_ff <= rad_ff - trial[SB-1:0];
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            iter_ff <= iter_ff - pals_pkg::ITER_BITS'(1);
         end
         S_ACC: begin
            if (!close_ff) begin
               cum_last_ff <= new_cum;
               prev_x_ff   <= cmd_ff.x;
               prev_y_ff   <= cmd_ff.y;
               if (cmd_ff.last) begin
                  close_ff <= 1'b1;
                  dx_ff    <= (count_ff == CW'(0)) ? DB'(0)
                                                   : DB'(first_x_ff) - DB'(cmd_ff.x);
                  dy_ff    <= (count_ff == CW'(0)) ? DB'(0)
                                                   : DB'(first_y_ff) - DB'(cmd_ff.y);
               end
            end
         end
         S_QMUL: begin
            target_ff <= TB'(cmd_ff.frac * perim_ff);
            status_ff <= pals_pkg::ST_NOT_FOUND;
         end
         S_QSC0: begin
            seg_ff <= '0;
            lo_ff  <= '0;
         end
         S_QSCAN: begin
            // rd_cum_ff holds the end of segment seg_ff
            if (target_ff <= TB'({rd_cum_ff, 16'd0})) begin
               num_ff  <= target_ff - TB'({lo_ff, 16'd0});
               dvs_ff  <= TB'({rd_cum_ff - lo_ff, 16'd0});
               t_ff    <= '0;
               iter_ff <= pals_pkg::ITER_BITS'(NB - 1);
            end else begin
               lo_ff  <= rd_cum_ff;
               seg_ff <= seg_ff + AW'(1);
            end
         end
         S_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (num_ff >= dvs_ff) begin
               num_ff <= num_ff - dvs_ff;
               t_ff   <= {t_ff[NB-2:0], 1'b1};
            end else begin
               t_ff <= {t_ff[NB-2:0], 1'b0};
            end
            dvs_ff  <= dvs_ff >> 1;
            iter_ff <= iter_ff - pals_pkg::ITER_BITS'(1);
         end
         S_RDB: begin
            ax_ff <= $signed(rd_x_ff);
            ay_ff <= $signed(rd_y_ff);
         end
         S_LERP: begin
            if (lerp_mul_ff) begin
               pos_x_ff   <= ax_ff + CB'(rndx >>> 16);
               pos_y_ff   <= ay_ff + CB'(rndy >>> 16);
               seg_out_ff <= seg_wide[pals_pkg::SEG_BITS-1:0];
               status_ff  <= pals_pkg::ST_OK;
            end else begin
               // products for the lerp, registered before the rounding add
               prodx_ff <= PB'(difx * $signed({1'b0, t_ff}));
               prody_ff <= PB'(dify * $signed({1'b0, t_ff}));
            end
         end
         default: begin
            dvs_ff <= dvs_ff;
         end
      endcase
   end

   // lerp multiply: end point data arrives in the first S_LERP cycle, the add in the second
   always_ff @(posedge clock) begin
      if (reset) begin
         lerp_mul_ff <= 1'b0;
      end else begin
         lerp_mul_ff <= (state_ff == S_LERP) && !lerp_mul_ff;
      end
   end

endmodule

// ===== design/polyline_arc_length_sampler.sv =====
// Polyline arc-length sampler. A load finds its segment length by a 17-step root, with a
// second root when it closes the path; a first or dropped vertex gets one only then. A query
// scans cumulative lengths with one read per cycle, then the 17-step bit-serial divide, which
// a zero-length segment skips; a failed scan gives not found, a missing closed path no path.
// One item in the back end at a time, next starts the cycle after its response beat.
// Synchronous active-high reset clears state, valid, count, perimeter, closed flag and queue.
module polyline_arc_length_sampler #(
   parameter int MAX_VERTICES = pals_pkg::MAX_VERTICES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pals_req_if.sink    req,
   pals_rsp_if.source  rsp
);

   logic              cmd_valid;
   logic              cmd_pop;
   pals_pkg::cmd_type cmd;

   pals_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   pals_back #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp)
   );

endmodule
